// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== rtl/core/psc_pkg.sv =====
// Shared types, constants and helper functions of the sample CSV formatter.
package psc_pkg;

  localparam int STAMP_W     = 16;
  localparam int SAMPLE_W    = 10;
  localparam int TENTHS_W    = 13;
  localparam int DIGITS      = 5;
  localparam int DIG_W       = 4;
  localparam int DIV_STAGES  = DIGITS - 1;
  localparam int IDX_W       = $clog2(DIGITS);

  // Queue depth must be a power of two: pointers wrap on overflow
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [STAMP_W-1:0]  PERIOD_RESET = 16'd500;
  localparam logic [TENTHS_W-1:0] TENTHS_SCALE = 13'd5000;
  localparam int                  SCALE_SHIFT  = 10;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [STAMP_W-1:0]  RECIP_10     = 16'hCCCD;
  localparam int                  RECIP_SHIFT  = 19;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [IDX_W-1:0] STAMP_LSD = '0;
  localparam logic [IDX_W-1:0] WHOLE_LSD = IDX_W'(1);

  // Decimal digits, index 0 is the least significant
  typedef logic [DIGITS-1:0][DIG_W-1:0] digits_t;

  // One pending line: stamp digits, tenths digits (index 0 is the fraction)
  typedef struct packed {
    digits_t stamp_dig;
    digits_t tenth_dig;
    logic    hb;
  } line_job_t;

  typedef enum logic [2:0] {
    PH_STAMP,
    PH_COMMA,
    PH_WHOLE,
    PH_POINT,
    PH_FRAC,
    PH_CR,
    PH_LF
  } phase_t;

  // Quotient by ten through the reciprocal multiply
  function automatic logic [STAMP_W-1:0] div10(logic [STAMP_W-1:0] x);
    logic [2*STAMP_W-1:0] prod;
    prod = x * RECIP_10;
    return STAMP_W'(prod >> RECIP_SHIFT);
  endfunction

  // Index of the most significant nonzero digit, never below floor_idx
  function automatic logic [IDX_W-1:0] top_digit(digits_t d, logic [IDX_W-1:0] floor_idx);
    logic [IDX_W-1:0] res;
    res = floor_idx;
    for (int i = 0; i < DIGITS; i++) begin
      if (IDX_W'(i) > floor_idx && d[i] != '0) begin
        res = IDX_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/periodic_sample_csv_formatter.sv =====
// With the back end idle, a due tick passes the scale stage, four digit stages, the queue
// write, the line load and the output register before its first byte shows.
// Throughput: ticks are taken every cycle while the line queue has room; the
// byte walker emits one byte per cycle while the output is taken; a line is 7 to 13 bytes.
// Reset clears tick counter, stamp, heartbeat and queue; the period returns to 500.
module periodic_sample_csv_formatter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [psc_pkg::SAMPLE_W-1:0] adc_sample,
  input  logic                         cfg_wr_en,
  input  logic [psc_pkg::STAMP_W-1:0]  cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   text_byte,
  output logic                         end_of_line,
  output logic                         heartbeat
);
  import psc_pkg::*;

  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  line_job_t push_data;
  line_job_t pop_data;

  // Classify ticks and convert stamps to digits
  psc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .adc_sample  (adc_sample),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  // Buffer pending lines
  psc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Emit line bytes
  psc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .text_byte   (text_byte),
    .end_of_line (end_of_line),
    .heartbeat   (heartbeat)
  );

endmodule

// ===== rtl/core/psc_front.sv =====
// Front end: tick accounting, due check and pipelined decimal conversion.
module psc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [psc_pkg::SAMPLE_W-1:0]     adc_sample,
  input  logic                             cfg_wr_en,
  input  logic [psc_pkg::STAMP_W-1:0]      cfg_wr_data,
  output logic                             push,
  output psc_pkg::line_job_t               push_data,
  input  logic                             q_full
);
  import psc_pkg::*;

  logic [STAMP_W-1:0] sample_period;
  logic [STAMP_W-1:0] tick_count;
  logic [STAMP_W-1:0] last_stamp;
  logic               heartbeat_level;

  logic               en;
  logic               accept;
  logic               due;
  logic [STAMP_W-1:0] tick_next;
  logic [STAMP_W-1:0] elapsed;
  logic [SAMPLE_W+TENTHS_W-1:0] scaled;

  logic [DIV_STAGES:0] st_v;
  logic [STAMP_W-1:0]  st_s  [0:DIV_STAGES];
  logic [STAMP_W-1:0]  st_t  [0:DIV_STAGES];
  digits_t             st_sd [0:DIV_STAGES];
  digits_t             st_td [0:DIV_STAGES];
  logic                st_hb [0:DIV_STAGES];

  logic [STAMP_W-1:0]  q_s [1:DIV_STAGES];
  logic [STAMP_W-1:0]  q_t [1:DIV_STAGES];
  logic [DIG_W-1:0]    r_s [1:DIV_STAGES];
  logic [DIG_W-1:0]    r_t [1:DIV_STAGES];
  digits_t             st_sd_next [1:DIV_STAGES];
  digits_t             st_td_next [1:DIV_STAGES];

  // Advance the whole pipeline unless the last stage is blocked by a full queue
  assign en       = !(st_v[DIV_STAGES] && q_full);
  assign in_ready = en;
  assign accept   = in_valid && en;

  // Check whether a line is due after this tick
  assign tick_next = tick_count + 1'b1;
  assign elapsed   = tick_next - last_stamp;
  assign due       = elapsed >= sample_period;

  // Scale the sample to tenths of a degree
  assign scaled = {{TENTHS_W{1'b0}}, adc_sample} * {{SAMPLE_W{1'b0}}, TENTHS_SCALE};

  // Hold tick, stamp, heartbeat and period
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period   <= PERIOD_RESET;
      tick_count      <= '0;
      last_stamp      <= '0;
      heartbeat_level <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sample_period <= cfg_wr_data;
      end
      if (accept) begin
        tick_count <= tick_next;
        if (due) begin
          last_stamp      <= last_stamp + sample_period;
          heartbeat_level <= ~heartbeat_level;
        end
      end
    end
  end

  // Split one decimal digit off each lane per stage
  always_comb begin
    for (int i = 1; i <= DIV_STAGES; i++) begin
      q_s[i] = div10(st_s[i-1]);
      q_t[i] = div10(st_t[i-1]);
      r_s[i] = DIG_W'(st_s[i-1] - ((q_s[i] << 3) + (q_s[i] << 1)));
      r_t[i] = DIG_W'(st_t[i-1] - ((q_t[i] << 3) + (q_t[i] << 1)));
      st_sd_next[i]      = st_sd[i-1];
      st_sd_next[i][i-1] = r_s[i];
      st_td_next[i]      = st_td[i-1];
      st_td_next[i][i-1] = r_t[i];
    end
  end

  // Shift stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= '0;
    end else if (en) begin
      st_v <= {st_v[DIV_STAGES-1:0], accept && due};
    end
  end

  // Shift stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      st_s[0]  <= last_stamp + sample_period;
      st_t[0]  <= STAMP_W'(scaled >> SCALE_SHIFT);
      st_sd[0] <= '0;
      st_td[0] <= '0;
      st_hb[0] <= ~heartbeat_level;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        st_s[i]  <= q_s[i];
        st_t[i]  <= q_t[i];
        st_sd[i] <= st_sd_next[i];
        st_td[i] <= st_td_next[i];
        st_hb[i] <= st_hb[i-1];
      end
    end
  end

  // Hand the finished digits to the queue; the last quotient is the top digit
  always_comb begin
    push_data                       = '0;
    push_data.stamp_dig             = st_sd[DIV_STAGES];
    push_data.stamp_dig[DIGITS-1]   = st_s[DIV_STAGES][DIG_W-1:0];
    push_data.tenth_dig             = st_td[DIV_STAGES];
    push_data.tenth_dig[DIGITS-1]   = st_t[DIV_STAGES][DIG_W-1:0];
    push_data.hb                    = st_hb[DIV_STAGES];
  end

  assign push = en && st_v[DIV_STAGES];

endmodule

// ===== rtl/core/psc_queue.sv =====
// Small register queue of pending lines between front and back end.
module psc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  psc_pkg::line_job_t push_data,
  output logic               full,
  input  logic               pop,
  output psc_pkg::line_job_t pop_data,
  output logic               empty
);
  import psc_pkg::*;

`include "assert_macros.svh"

  line_job_t          entries [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `ASSERT_IMPLY(a_no_overflow, clk, rst, push, !full)
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, !empty)
  `ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))

endmodule

// ===== rtl/core/psc_back.sv =====
// Back end: walks one pending line and emits it byte by byte.
module psc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  psc_pkg::line_job_t pop_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         text_byte,
  output logic               end_of_line,
  output logic               heartbeat
);
  import psc_pkg::*;

`include "assert_macros.svh"

  phase_t            phase;
  phase_t            phase_next;
  logic              busy;
  logic              busy_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  line_job_t         job;

  logic              step;
  logic              load;
  logic [7:0]        cur_byte;

  // Move a byte whenever the output register is free or being drained
  assign step = busy && (!out_valid || out_ready);
  assign load = !q_empty && (!busy || (step && phase == PH_LF));
  assign pop  = load;

  // Hold phase, digit pointer and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_STAMP;
      busy  <= 1'b0;
      idx   <= '0;
    end else begin
      phase <= phase_next;
      busy  <= busy_next;
      idx   <= idx_next;
    end
  end

  // Walk the fields of the line
  always_comb begin
    phase_next = phase;
    busy_next  = busy;
    idx_next   = idx;
    cur_byte   = CHAR_LF;
    unique case (phase)
      PH_STAMP: cur_byte = CHAR_ZERO + {4'b0, job.stamp_dig[idx]};
      PH_COMMA: cur_byte = CHAR_COMMA;
      PH_WHOLE: cur_byte = CHAR_ZERO + {4'b0, job.tenth_dig[idx]};
      PH_POINT: cur_byte = CHAR_POINT;
      PH_FRAC:  cur_byte = CHAR_ZERO + {4'b0, job.tenth_dig[0]};
      PH_CR:    cur_byte = CHAR_CR;
      PH_LF:    cur_byte = CHAR_LF;
      default:  cur_byte = CHAR_LF;
    endcase
    if (step) begin
      unique case (phase)
        PH_STAMP: begin
          if (idx == STAMP_LSD) begin
            phase_next = PH_COMMA;
          end else begin
            idx_next = idx - 1'b1;
          end
        end
        PH_COMMA: begin
          phase_next = PH_WHOLE;
          idx_next   = top_digit(job.tenth_dig, WHOLE_LSD);
        end
        PH_WHOLE: begin
          if (idx == WHOLE_LSD) begin
            phase_next = PH_POINT;
          end else begin
            idx_next = idx - 1'b1;
          end
        end
        PH_POINT: phase_next = PH_FRAC;
        PH_FRAC:  phase_next = PH_CR;
        PH_CR:    phase_next = PH_LF;
        PH_LF: begin
          phase_next = PH_STAMP;
          busy_next  = 1'b0;
        end
        default:  phase_next = PH_STAMP;
      endcase
    end
    if (load) begin
      busy_next  = 1'b1;
      phase_next = PH_STAMP;
      idx_next   = top_digit(pop_data.stamp_dig, STAMP_LSD);
    end
  end

  // Latch the next line from the queue
  always_ff @(posedge clk) begin
    if (load) begin
      job <= pop_data;
    end
  end

  // Output register: hold a byte until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      text_byte   <= cur_byte;
      end_of_line <= phase == PH_LF;
      heartbeat   <= job.hb;
    end
  end

  `ASSERT_IMPLY(a_eol_is_lf, clk, rst, out_valid && end_of_line, text_byte == CHAR_LF)
  `ASSERT_IMPLY(a_whole_idx, clk, rst, busy && phase == PH_WHOLE, idx >= WHOLE_LSD)
  `ASSERT_NEXT(a_lf_shown, clk, rst, step && phase == PH_LF, out_valid && end_of_line)

endmodule
